@@ hw/rtl/sme_pkg.sv @@
`default_nettype none
package sme_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int INSTR_W         = 32;
  localparam int HDR_SHIFT       = 30;
  localparam int DATA_W          = HDR_SHIFT;
  localparam int WORD_W          = 32;
  localparam int DEPTH_W         = 9;
  localparam int FAULT_W         = 2;
  localparam int DIV_STEPS       = WORD_W;
  localparam int STEP_W          = $clog2(DIV_STEPS);

  // primitive codes carried in the data field
  localparam logic [DATA_W-1:0] PRIM_HALT = DATA_W'(0);
  localparam logic [DATA_W-1:0] PRIM_ADD  = DATA_W'(1);
  localparam logic [DATA_W-1:0] PRIM_SUB  = DATA_W'(2);
  localparam logic [DATA_W-1:0] PRIM_MUL  = DATA_W'(3);
  localparam logic [DATA_W-1:0] PRIM_DIV  = DATA_W'(4);

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_DIVZ  = 2'd3
  } fault_t;

  typedef enum logic [2:0] {
    OP_HALT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

  typedef struct packed {
    logic   capture;
    logic   push;
    logic   set_halt;
    logic   rd_issue;
    logic   load_a;
    logic   exec_alu;
    logic   div_start;
    logic   div_step;
    logic   wb;
    logic   set_fault;
    fault_t fault;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic is_push;
    op_t  op;
    logic halted;
    logic full;
    logic lt2;
    logic b_zero;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/sme_ram.sv @@
`default_nettype none
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sme_ctrl.sv @@
`default_nettype none
module sme_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire sme_pkg::sts_t sts,
  output sme_pkg::cmd_t      cmd
);

  import sme_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.halted || sts.is_push) begin
          state_nxt = S_DONE;
        end else begin
          unique case (sts.op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_nxt = sts.lt2 ? S_DONE : S_READ;
            default:                        state_nxt = S_DONE;
          endcase
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.op == OP_DIV) begin
          state_nxt = sts.b_zero ? S_DONE : S_DIV;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_WB;
      end
      S_WB: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    cmd.fault = FAULT_NONE;
    unique case (state_r)
      S_IDLE: cmd.capture = in_valid;
      S_DECODE: begin
        if (!sts.halted) begin
          if (sts.is_push) begin
            if (sts.full) begin
              cmd.set_fault = 1'b1;
              cmd.fault     = FAULT_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end else begin
            unique case (sts.op)
              OP_HALT: cmd.set_halt = 1'b1;
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (sts.lt2) begin
                  cmd.set_fault = 1'b1;
                  cmd.fault     = FAULT_UNDER;
                end else begin
                  cmd.rd_issue = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_READ: cmd.load_a = 1'b1;
      S_EXEC: begin
        if (sts.op == OP_DIV) begin
          if (sts.b_zero) begin
            cmd.set_fault = 1'b1;
            cmd.fault     = FAULT_DIVZ;
          end else begin
            cmd.div_start = 1'b1;
          end
        end else begin
          cmd.exec_alu = 1'b1;
        end
      end
      S_DIV:  cmd.div_step = 1'b1;
      S_WB:   cmd.wb = 1'b1;
      S_DONE: cmd.out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ hw/rtl/sme_dpath.sv @@
`default_nettype none
module sme_dpath #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sme_pkg::cmd_t                     cmd,
  output sme_pkg::sts_t                          sts,
  input  wire logic [sme_pkg::INSTR_W-1:0]       in_instruction,
  output logic signed [sme_pkg::WORD_W-1:0]      out_top_value,
  output logic        [sme_pkg::DEPTH_W-1:0]     out_depth_now,
  output logic                                   out_stopped,
  output logic        [sme_pkg::FAULT_W-1:0]     out_fault
);

  import sme_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [INSTR_W-1:0] instr_r, instr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               halted_r, halted_nxt;
  logic [WORD_W-1:0]  top_r, top_nxt;
  logic [WORD_W-1:0]  a_r, a_nxt;
  logic [WORD_W-1:0]  res_r, res_nxt;
  fault_t             fault_r, fault_nxt;
  logic [WORD_W-1:0]  rem_r, rem_nxt;
  logic [WORD_W-1:0]  quo_r, quo_nxt;
  logic [WORD_W-1:0]  dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic signed [WORD_W-1:0]  otop_r, otop_nxt;
  logic [DEPTH_W-1:0]        odepth_r, odepth_nxt;
  logic                      ostop_r, ostop_nxt;
  logic [FAULT_W-1:0]        ofault_r, ofault_nxt;

  logic [INSTR_W-HDR_SHIFT-1:0] hdr;
  logic [DATA_W-1:0]            data;
  logic [WORD_W-1:0]            data_ext;
  op_t                          op;
  logic [CW-1:0]                below_top;
  logic [WORD_W-1:0]            prod_lo;
  logic [WORD_W:0]              rem_sh;
  logic [WORD_W:0]              trial;
  logic [WORD_W-1:0]            quo_fix;
  logic [WORD_W-1:0]            wb_val;
  logic [CW+DEPTH_W-1:0]        depth_ext;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  assign hdr       = instr_r[INSTR_W-1:HDR_SHIFT];
  assign data      = instr_r[DATA_W-1:0];
  assign data_ext  = {{(WORD_W-DATA_W){1'b0}}, data};
  assign below_top = count_r - CW'(2);
  assign prod_lo   = a_r * top_r;
  assign rem_sh    = {rem_r, quo_r[WORD_W-1]};
  assign trial     = rem_sh - {1'b0, dvs_r};
  assign quo_fix   = neg_r ? (WORD_W'(0) - quo_r) : quo_r;
  assign wb_val    = (op == OP_DIV) ? quo_fix : res_r;
  assign depth_ext = {{DEPTH_W{1'b0}}, count_r};

  always_comb begin
    if (data == PRIM_HALT) begin
      op = OP_HALT;
    end else if (data == PRIM_ADD) begin
      op = OP_ADD;
    end else if (data == PRIM_SUB) begin
      op = OP_SUB;
    end else if (data == PRIM_MUL) begin
      op = OP_MUL;
    end else if (data == PRIM_DIV) begin
      op = OP_DIV;
    end else begin
      op = OP_NOP;
    end
  end

  always_comb begin
    sts.is_push  = !hdr[0];
    sts.op       = op;
    sts.halted   = halted_r;
    sts.full     = (count_r >= CW'(STACK_DEPTH));
    sts.lt2      = (count_r < CW'(2));
    sts.b_zero   = (top_r == '0);
    sts.div_last = (step_r == STEP_W'(DIV_STEPS - 1));
  end

  always_comb begin
    instr_nxt  = cmd.capture ? in_instruction : instr_r;
    count_nxt  = count_r;
    halted_nxt = halted_r || cmd.set_halt;
    top_nxt    = top_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = data_ext;
    end
    if (cmd.wb) begin
      count_nxt = count_r - CW'(1);
      top_nxt   = wb_val;
    end

    a_nxt = cmd.load_a ? ram_rdata : a_r;

    res_nxt = res_r;
    if (cmd.exec_alu) begin
      unique case (op)
        OP_ADD:  res_nxt = a_r + top_r;
        OP_SUB:  res_nxt = a_r - top_r;
        OP_MUL:  res_nxt = prod_lo;
        default: res_nxt = res_r;
      endcase
    end

    // restoring divide on magnitudes, one quotient bit per step
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    if (cmd.div_start) begin
      rem_nxt  = '0;
      quo_nxt  = a_r[WORD_W-1] ? (WORD_W'(0) - a_r) : a_r;
      dvs_nxt  = top_r[WORD_W-1] ? (WORD_W'(0) - top_r) : top_r;
      neg_nxt  = a_r[WORD_W-1] ^ top_r[WORD_W-1];
      step_nxt = '0;
    end else if (cmd.div_step) begin
      if (!trial[WORD_W]) begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
    end

    fault_nxt = fault_r;
    if (cmd.capture)   fault_nxt = FAULT_NONE;
    if (cmd.set_fault) fault_nxt = cmd.fault;

    otop_nxt   = otop_r;
    odepth_nxt = odepth_r;
    ostop_nxt  = ostop_r;
    ofault_nxt = ofault_r;
    if (cmd.out_load) begin
      otop_nxt   = (count_r != '0) ? top_r : '0;
      odepth_nxt = depth_ext[DEPTH_W-1:0];
      ostop_nxt  = halted_r;
      ofault_nxt = fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      halted_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    instr_r  <= instr_nxt;
    top_r    <= top_nxt;
    a_r      <= a_nxt;
    res_r    <= res_nxt;
    fault_r  <= fault_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    neg_r    <= neg_nxt;
    step_r   <= step_nxt;
    otop_r   <= otop_nxt;
    odepth_r <= odepth_nxt;
    ostop_r  <= ostop_nxt;
    ofault_r <= ofault_nxt;
  end

  assign ram_we    = cmd.push || cmd.wb;
  assign ram_waddr = cmd.push ? count_r[AW-1:0] : below_top[AW-1:0];
  assign ram_wdata = cmd.push ? data_ext : wb_val;

  sme_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.rd_issue),
    .raddr   (below_top[AW-1:0]),
    .rdata_r (ram_rdata)
  );

  assign out_top_value = otop_r;
  assign out_depth_now = odepth_r;
  assign out_stopped   = ostop_r;
  assign out_fault     = ofault_r;

endmodule
`default_nettype wire

@@ hw/rtl/stack_machine_executor_unit.sv @@
`default_nettype none
// Stack machine executor. Each request is one 32-bit instruction word: bits
// 31:30 are the header, bits 29:0 the data. An even header pushes the data
// zero-extended; an odd header runs primitive 0 halt, 1 add, 2 sub, 3 mul or
// 4 signed divide (truncating) on second-from-top OP top, popping both and
// pushing the result; other codes do nothing. Every request returns exactly
// one result: the top of stack (zero when empty), the depth, the stopped flag
// and a fault code (underflow, overflow, divide by zero), with the stack left
// unchanged on a fault. After a halt, requests are taken but change nothing
// until reset. One request is in work at a time. Push, halt, no-op, faults found
// at decode and all requests after a halt end at decode; add, sub and mul go on
// to operand read, execute and write back; a divide by zero ends at execute; a
// divide adds the radix-2 divider, which retires one quotient bit per cycle.
// The second operand is read from a stack RAM with registered read; the top
// entry sits in a register. A finished result waits in an output register, so
// the next request may be accepted while the previous result is still stalled;
// it completes once that register is free. The stack RAM needs no clearing
// pass: only entries below the current depth are ever read.
module stack_machine_executor_unit #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // instruction request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [sme_pkg::INSTR_W-1:0]       in_instruction,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [sme_pkg::WORD_W-1:0]      out_top_value,
  output logic        [sme_pkg::DEPTH_W-1:0]     out_depth_now,
  output logic                                   out_stopped,
  output logic        [sme_pkg::FAULT_W-1:0]     out_fault
);

  import sme_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decode, operand fetch, execute, write back, hand off result
  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: stack RAM, top register, ALU, divider, output register
  sme_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_instruction (in_instruction),
    .out_top_value  (out_top_value),
    .out_depth_now  (out_depth_now),
    .out_stopped    (out_stopped),
    .out_fault      (out_fault)
  );

endmodule
`default_nettype wire

@@ hw/rtl/sme_checker.sv @@
`default_nettype none
module sme_checker #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [sme_pkg::WORD_W-1:0] out_top_value,
  input wire logic        [sme_pkg::DEPTH_W-1:0] out_depth_now,
  input wire logic                              out_stopped,
  input wire logic        [sme_pkg::FAULT_W-1:0] out_fault
);

  import sme_pkg::*;

  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still in work");

  // once stopped, every later result stays stopped
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_stopped |=> out_stopped)
    else $error("stopped flag dropped");

  // a stopped machine reports no faults
  a_no_fault_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped |-> out_fault == FAULT_NONE)
    else $error("fault reported after halt");

  // overflow only on a full stack
  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault == FAULT_OVER |-> out_depth_now == FULL_DEPTH)
    else $error("overflow reported below full depth");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_top_value))
    else $error("stalled result changed");

endmodule

bind stack_machine_executor_unit sme_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_sme_checker (.*);
`default_nettype wire
